// ===== rtl/core/fk_pkg.sv =====
// ----------------------------------------------------------------------------
// fk_pkg - shared types and constants of the fragmentation tracker
// Command codes, counter numbers, table depth and the structs that run
// between the control logic, the cell chain and the counter bank.
// ----------------------------------------------------------------------------
package fk_pkg;

    localparam int TOP_K     = 100;   // ranked slots per statistics set
    localparam int NUM_CNT   = 6;     // counters per statistics set
    localparam int INO_W     = 48;
    localparam int EXT_W     = 32;
    localparam int VAL_W     = 64;
    localparam int IDX_W     = 7;
    localparam int CNT_IDX_W = 4;     // addresses the twelve counters

    typedef enum logic [1:0] {
        CMD_RECORD  = 2'd0,
        CMD_ENTRY   = 2'd1,
        CMD_COUNTER = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        CNT_FILES     = 3'd0,
        CNT_RESIDENT  = 3'd1,
        CNT_SPARSE    = 3'd2,
        CNT_NONSPARSE = 3'd3,
        CNT_FRAG      = 3'd4,
        CNT_EXTENTS   = 3'd5
    } t_cnt_id;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WAIT = 1'b1
    } t_state;

    // insertion request broadcast to every cell
    typedef struct packed {
        logic             vld;
        logic             set;
        logic [INO_W-1:0] ino;
        logic [EXT_W-1:0] ext;
    } t_ins;

    // entry read request walking down the chain
    typedef struct packed {
        logic             vld;
        logic             set;
        logic [IDX_W-1:0] idx;
        logic [INO_W-1:0] ino;
        logic [EXT_W-1:0] ext;
    } t_rd_bus;

    // counter update of one record request
    typedef struct packed {
        logic             vld;
        logic             set;
        logic             nonres;
        logic             hole;
        logic [EXT_W-1:0] ext;
    } t_rec;

endpackage

// ===== rtl/core/fk_cell.sv =====
// ----------------------------------------------------------------------------
// fk_cell - one rank slot of the sorted chain
// Holds the slot of both sets, takes a new key or the left neighbor's entry
// on insertion, and passes the entry read request on to the next cell.
// ----------------------------------------------------------------------------
module fk_cell
    import fk_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_cell_idx,
    input  t_ins             i_ins,
    input  logic             i_prev_gt,
    input  logic [INO_W-1:0] i_prev_ino,
    input  logic [EXT_W-1:0] i_prev_ext,
    output logic             o_gt,
    output logic [INO_W-1:0] o_ino,
    output logic [EXT_W-1:0] o_ext,
    input  t_rd_bus          i_rd,
    output t_rd_bus          o_rd
);

    logic [INO_W-1:0] r_ino [2];
    logic [EXT_W-1:0] r_ext [2];
    t_rd_bus          r_rd;
    t_rd_bus          n_rd;
    logic             w_gt;

    assign w_gt  = i_ins.vld && (i_ins.ext > r_ext[i_ins.set]);
    assign o_gt  = w_gt;
    assign o_ino = r_ino[i_ins.set];
    assign o_ext = r_ext[i_ins.set];
    assign o_rd  = r_rd;

    // slot storage: shift down from the left or take the new key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext[0] <= '0;
            r_ext[1] <= '0;
            r_ino[0] <= '0;
            r_ino[1] <= '0;
        end else if (w_gt) begin
            r_ext[i_ins.set] <= i_prev_gt ? i_prev_ext : i_ins.ext;
            r_ino[i_ins.set] <= i_prev_gt ? i_prev_ino : i_ins.ino;
        end
    end

    // read request: advance one cell, load the slot when it is the target
    always_comb begin
        n_rd = i_rd;
        if (i_rd.vld && (i_rd.idx == i_cell_idx)) begin
            n_rd.ino = r_ino[i_rd.set];
            n_rd.ext = r_ext[i_rd.set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
        end else begin
            r_rd <= n_rd;
        end
    end

endmodule

// ===== rtl/core/fk_counters.sv =====
// ----------------------------------------------------------------------------
// fk_counters - statistics counter bank
// Twelve wrapping 64-bit counters, six per set, updated by record requests
// and read at one address.
// ----------------------------------------------------------------------------
module fk_counters
    import fk_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_rec             i_rec,
    input  logic             i_rd_set,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [VAL_W-1:0] o_rd_value,
    output logic             o_rd_ok
);

    localparam int NUM_ALL = 2 * NUM_CNT;

    logic [VAL_W-1:0]     r_cnt [NUM_ALL];
    logic [VAL_W-1:0]     n_cnt [NUM_ALL];
    logic [CNT_IDX_W-1:0] w_base;
    logic [CNT_IDX_W-1:0] w_rd_base;
    logic [CNT_IDX_W-1:0] w_rd_addr;

    assign w_base    = i_rec.set ? CNT_IDX_W'(NUM_CNT) : '0;
    assign w_rd_base = i_rd_set ? CNT_IDX_W'(NUM_CNT) : '0;
    assign w_rd_addr = w_rd_base + CNT_IDX_W'(i_rd_idx[2:0]);
    assign o_rd_ok   = (i_rd_idx < IDX_W'(NUM_CNT));
    assign o_rd_value = o_rd_ok ? r_cnt[w_rd_addr] : '0;

    always_comb begin
        for (int k = 0; k < NUM_ALL; k++) begin
            n_cnt[k] = r_cnt[k];
        end
        if (i_rec.vld) begin
            n_cnt[w_base + CNT_IDX_W'(CNT_FILES)] =
                r_cnt[w_base + CNT_IDX_W'(CNT_FILES)] + VAL_W'(1);
            if (!i_rec.nonres) begin
                n_cnt[w_base + CNT_IDX_W'(CNT_RESIDENT)] =
                    r_cnt[w_base + CNT_IDX_W'(CNT_RESIDENT)] + VAL_W'(1);
            end else if (i_rec.hole || (i_rec.ext == '0)) begin
                n_cnt[w_base + CNT_IDX_W'(CNT_SPARSE)] =
                    r_cnt[w_base + CNT_IDX_W'(CNT_SPARSE)] + VAL_W'(1);
            end else begin
                n_cnt[w_base + CNT_IDX_W'(CNT_NONSPARSE)] =
                    r_cnt[w_base + CNT_IDX_W'(CNT_NONSPARSE)] + VAL_W'(1);
                if (i_rec.ext > EXT_W'(1)) begin
                    n_cnt[w_base + CNT_IDX_W'(CNT_FRAG)] =
                        r_cnt[w_base + CNT_IDX_W'(CNT_FRAG)] + VAL_W'(1);
                end
                n_cnt[w_base + CNT_IDX_W'(CNT_EXTENTS)] =
                    r_cnt[w_base + CNT_IDX_W'(CNT_EXTENTS)] + VAL_W'(i_rec.ext);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ALL; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            for (int k = 0; k < NUM_ALL; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

endmodule

// ===== rtl/core/top_k_fragmentation_tracker_core.sv =====
// ----------------------------------------------------------------------------
// top_k_fragmentation_tracker_core - per-class fragmentation statistics
// Keeps six counters and a descending top-K table of extent counts for the
// directory and the non-directory class, and answers read requests.
// ----------------------------------------------------------------------------
// Record request: no result; a new request is taken the next cycle.
// Counter read, and an entry read with a rank of TOP_K or more: result strobed
//   in the cycle after acceptance.
// Entry read: busy while the request walks the cell chain one cell per cycle;
//   the result is strobed after the request leaves the last cell.
// Synchronous active-low reset clears counters and tables.
// ----------------------------------------------------------------------------
module top_k_fragmentation_tracker_core
    import fk_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_cmd,
    input  logic [INO_W-1:0] i_inode_number,
    input  logic [EXT_W-1:0] i_extent_count,
    input  logic             i_is_directory,
    input  logic             i_is_nonresident,
    input  logic             i_has_hole,
    input  logic             i_set_select,
    input  logic [IDX_W-1:0] i_read_index,
    output logic             o_strobe,
    output logic [VAL_W-1:0] o_read_value,
    output logic [EXT_W-1:0] o_read_extents,
    output logic             o_entry_valid
);

    t_state           r_state, n_state;
    logic             r_strobe, n_strobe;
    logic [VAL_W-1:0] r_value, n_value;
    logic [EXT_W-1:0] r_extents, n_extents;
    logic             r_valid, n_valid;

    t_cmd             w_cmd;
    logic             w_accept;
    logic             w_idx_ok;
    t_ins             w_ins;
    t_rec             w_rec;
    t_rd_bus          w_launch;
    logic [VAL_W-1:0] w_cnt_value;
    logic             w_cnt_ok;

    // insertion chain signals: index 0 is the left edge (nothing ranks above)
    logic             w_gt  [TOP_K+1];
    logic [INO_W-1:0] w_ino [TOP_K+1];
    logic [EXT_W-1:0] w_ext [TOP_K+1];
    t_rd_bus          w_rd  [TOP_K+1];

    assign w_cmd    = t_cmd'(i_cmd);
    assign busy     = (r_state == ST_WAIT);
    assign w_accept = start && !busy;
    assign w_idx_ok = ({1'b0, i_read_index} < (IDX_W+1)'(TOP_K));

    // counters see every record request
    always_comb begin
        w_rec.vld    = w_accept && (w_cmd == CMD_RECORD);
        w_rec.set    = i_is_directory;
        w_rec.nonres = i_is_nonresident;
        w_rec.hole   = i_has_hole;
        w_rec.ext    = i_extent_count;
    end

    // only nonsparse nonresident files with more than one extent are ranked
    always_comb begin
        w_ins.vld = w_rec.vld && i_is_nonresident && !i_has_hole
                    && (i_extent_count > EXT_W'(1));
        w_ins.set = i_is_directory;
        w_ins.ino = i_inode_number;
        w_ins.ext = i_extent_count;
    end

    // entry read request entering the head of the chain
    always_comb begin
        w_launch.vld = w_accept && (w_cmd == CMD_ENTRY) && w_idx_ok;
        w_launch.set = i_set_select;
        w_launch.idx = i_read_index;
        w_launch.ino = '0;
        w_launch.ext = '0;
    end

    assign w_gt[0]  = 1'b0;
    assign w_ino[0] = '0;
    assign w_ext[0] = '0;
    assign w_rd[0]  = w_launch;

    // the cell chain: cell i holds rank i of both sets
    for (genvar i = 0; i < TOP_K; i++) begin : g_cell
        fk_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(i)),
            .i_ins      (w_ins),
            .i_prev_gt  (w_gt[i]),
            .i_prev_ino (w_ino[i]),
            .i_prev_ext (w_ext[i]),
            .o_gt       (w_gt[i+1]),
            .o_ino      (w_ino[i+1]),
            .o_ext      (w_ext[i+1]),
            .i_rd       (w_rd[i]),
            .o_rd       (w_rd[i+1])
        );
    end

    fk_counters u_counters (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rec      (w_rec),
        .i_rd_set   (i_set_select),
        .i_rd_idx   (i_read_index),
        .o_rd_value (w_cnt_value),
        .o_rd_ok    (w_cnt_ok)
    );

    // control: hold busy while an entry read is in the chain
    always_comb begin
        n_state   = r_state;
        n_strobe  = 1'b0;
        n_value   = r_value;
        n_extents = r_extents;
        n_valid   = r_valid;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_cmd)
                        CMD_ENTRY: begin
                            if (w_idx_ok) begin
                                n_state = ST_WAIT;
                            end else begin
                                // rank beyond the table: empty answer
                                n_strobe  = 1'b1;
                                n_value   = '0;
                                n_extents = '0;
                                n_valid   = 1'b0;
                            end
                        end
                        CMD_COUNTER: begin
                            n_strobe  = 1'b1;
                            n_value   = w_cnt_value;
                            n_extents = '0;
                            n_valid   = w_cnt_ok;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WAIT: begin
                if (w_rd[TOP_K].vld) begin
                    // a zero extent count marks an empty slot
                    n_state   = ST_IDLE;
                    n_strobe  = 1'b1;
                    n_valid   = (w_rd[TOP_K].ext != '0);
                    n_value   = n_valid ? VAL_W'(w_rd[TOP_K].ino) : '0;
                    n_extents = w_rd[TOP_K].ext;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_extents <= n_extents;
        r_valid   <= n_valid;
    end

    assign o_strobe       = r_strobe;
    assign o_read_value   = r_value;
    assign o_read_extents = r_extents;
    assign o_entry_valid  = r_valid;

    // the request reaches the chain end after walking every cell of the chain
    a_read_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> ##(TOP_K-1) w_rd[TOP_K].vld)
        else $error("entry read did not reach the chain end on time");

    a_end_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd[TOP_K].vld |-> (r_state == ST_WAIT))
        else $error("read request left the chain while idle");

    a_end_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd[TOP_K].vld |=> o_strobe)
        else $error("chain read produced no result");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_entry_valid) |-> (o_read_value == '0 && o_read_extents == '0))
        else $error("invalid result carries nonzero data");

    for (genvar i = 1; i < TOP_K; i++) begin : g_sorted
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_ext[i] >= w_ext[i+1])
            else $error("ranked table out of order");
    end

endmodule

// ===== dv/tb_top_k_fragmentation_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top_k_fragmentation_tracker_core - self-checking bench of the tracker
// Drives record, entry read, counter read and unused requests through the
// start/busy handshake, first directed, then in random bursts. A mirror of both statistics sets
// predicts every read and checks each strobed result in order.
// ----------------------------------------------------------------------------

import fk_pkg::*;

typedef struct {
    t_cmd             cmd;
    logic [INO_W-1:0] ino;
    logic [EXT_W-1:0] ext;
    logic             is_dir;
    logic             nonres;
    logic             hole;
    logic             sel;
    logic [IDX_W-1:0] idx;
} t_frag_req;

typedef struct {
    logic [VAL_W-1:0] value;
    logic [EXT_W-1:0] extents;
    logic             valid;
} t_frag_reply;

class frag_stats_mirror;
    bit [INO_W-1:0] ranked_ino [2][TOP_K];
    bit [EXT_W-1:0] ranked_ext [2][TOP_K];
    bit [VAL_W-1:0] counters   [2][NUM_CNT];
    t_frag_reply    due_replies[$];
    int             mismatches;

    function new();
        mismatches = 0;
    endfunction

    function int outstanding();
        return due_replies.size();
    endfunction

    // Sorted insertion: equal counts stay above the newcomer.
    function void insert_ranked(int s, bit [INO_W-1:0] ino, bit [EXT_W-1:0] ext);
        int pos;
        if (ext <= ranked_ext[s][TOP_K-1])
            return;
        pos = 0;
        while (pos < TOP_K && ext <= ranked_ext[s][pos])
            pos++;
        for (int j = TOP_K - 1; j > pos; j--) begin
            ranked_ino[s][j] = ranked_ino[s][j-1];
            ranked_ext[s][j] = ranked_ext[s][j-1];
        end
        ranked_ino[s][pos] = ino;
        ranked_ext[s][pos] = ext;
    endfunction

    function void take_request(t_frag_req r);
        t_frag_reply rep;
        int          s;
        rep.value   = '0;
        rep.extents = '0;
        rep.valid   = 1'b0;
        case (r.cmd)
            CMD_RECORD: begin
                s = int'(r.is_dir);
                counters[s][CNT_FILES]++;
                if (!r.nonres) begin
                    counters[s][CNT_RESIDENT]++;
                end else if (r.hole || r.ext == '0) begin
                    counters[s][CNT_SPARSE]++;
                end else begin
                    counters[s][CNT_NONSPARSE]++;
                    if (r.ext > 1) begin
                        counters[s][CNT_FRAG]++;
                        insert_ranked(s, r.ino, r.ext);
                    end
                    counters[s][CNT_EXTENTS] += VAL_W'(r.ext);
                end
            end
            CMD_ENTRY: begin
                s = int'(r.sel);
                if (r.idx < TOP_K && ranked_ext[s][r.idx] != '0) begin
                    rep.value   = VAL_W'(ranked_ino[s][r.idx]);
                    rep.extents = ranked_ext[s][r.idx];
                    rep.valid   = 1'b1;
                end
                due_replies.push_back(rep);
            end
            CMD_COUNTER: begin
                s = int'(r.sel);
                if (r.idx < NUM_CNT) begin
                    rep.value = counters[s][r.idx];
                    rep.valid = 1'b1;
                end
                due_replies.push_back(rep);
            end
            default: ;
        endcase
    endfunction

    function void match_reply(logic [VAL_W-1:0] value, logic [EXT_W-1:0] extents,
                              logic valid);
        t_frag_reply want;
        if (due_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: value %h extents %h valid %b",
                         value, extents, valid);
            return;
        end
        want = due_replies.pop_front();
        if (value !== want.value || extents !== want.extents || valid !== want.valid) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: exp %h %h %b, got %h %h %b",
                         want.value, want.extents, want.valid, value, extents, valid);
        end
    endfunction
endclass

module tb_top_k_fragmentation_tracker_core;

    localparam int RAND_ITEMS  = 1025;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN       = TOP_K + 10;

    logic             i_clk            = 1'b0;
    logic             i_rst_n          = 1'b0;
    logic             start            = 1'b0;
    logic             busy;
    logic [1:0]       i_cmd            = CMD_NONE;
    logic [INO_W-1:0] i_inode_number   = '0;
    logic [EXT_W-1:0] i_extent_count   = '0;
    logic             i_is_directory   = 1'b0;
    logic             i_is_nonresident = 1'b0;
    logic             i_has_hole       = 1'b0;
    logic             i_set_select     = 1'b0;
    logic [IDX_W-1:0] i_read_index     = '0;
    logic             o_strobe;
    logic [VAL_W-1:0] o_read_value;
    logic [EXT_W-1:0] o_read_extents;
    logic             o_entry_valid;

    frag_stats_mirror mirror = new();
    int               cycle_count = 0;

    top_k_fragmentation_tracker_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_inode_number   (i_inode_number),
        .i_extent_count   (i_extent_count),
        .i_is_directory   (i_is_directory),
        .i_is_nonresident (i_is_nonresident),
        .i_has_hole       (i_has_hole),
        .i_set_select     (i_set_select),
        .i_read_index     (i_read_index),
        .o_strobe         (o_strobe),
        .o_read_value     (o_read_value),
        .o_read_extents   (o_read_extents),
        .o_entry_valid    (o_entry_valid)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: a hung handshake or a lost result ends here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top_k_fragmentation_tracker_core: done, errors");
        $finish;
    end

    // Results cannot be held off: check every strobe at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1)
            mirror.match_reply(o_read_value, o_read_extents, o_entry_valid);
    end

    // Present one request and hold it until the block takes it (start high, busy
    // low at a rising edge). Returns at the accepting edge with start still high.
    task automatic send_request(input t_frag_req r);
        start            <= 1'b1;
        i_cmd            <= r.cmd;
        i_inode_number   <= r.ino;
        i_extent_count   <= r.ext;
        i_is_directory   <= r.is_dir;
        i_is_nonresident <= r.nonres;
        i_has_hole       <= r.hole;
        i_set_select     <= r.sel;
        i_read_index     <= r.idx;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        mirror.take_request(r);
    endtask

    // Record request; the read fields are ignored, so scramble them.
    task automatic send_record(input logic is_dir, input logic nonres, input logic hole,
                               input logic [INO_W-1:0] ino, input logic [EXT_W-1:0] ext);
        t_frag_req r;
        r.cmd    = CMD_RECORD;
        r.ino    = ino;
        r.ext    = ext;
        r.is_dir = is_dir;
        r.nonres = nonres;
        r.hole   = hole;
        r.sel    = 1'($urandom_range(0, 1));
        r.idx    = IDX_W'($urandom_range(0, 127));
        send_request(r);
    endtask

    // Read (or unused) request; the record fields are ignored, so scramble them.
    task automatic send_read(input t_cmd cmd, input logic sel, input int idx);
        t_frag_req r;
        r.cmd    = cmd;
        r.ino    = INO_W'({$urandom(), $urandom()});
        r.ext    = $urandom();
        r.is_dir = 1'($urandom_range(0, 1));
        r.nonres = 1'($urandom_range(0, 1));
        r.hole   = 1'($urandom_range(0, 1));
        r.sel    = sel;
        r.idx    = IDX_W'(idx);
        send_request(r);
    endtask

    initial begin
        int               n_items;
        int               burst_left;
        int               gap;
        int               pick;
        bit               hold;
        logic [INO_W-1:0] ino;
        logic [EXT_W-1:0] ext;

        // Hold reset, then leave the block idle briefly.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part: empty tables, every record class, ties, range edges.
        send_read(CMD_ENTRY, 1'b0, 0);                          // empty slot
        send_read(CMD_COUNTER, 1'b1, int'(CNT_EXTENTS));        // counter at reset
        send_record(1'b0, 1'b0, 1'b1, 48'h1234, 32'hFFFF_FFFF); // resident: ext ignored
        send_record(1'b0, 1'b1, 1'b1, 48'h2222, 32'd7);         // hole: sparse
        send_record(1'b0, 1'b1, 1'b0, 48'h3333, 32'd0);         // no extents: sparse
        send_record(1'b0, 1'b1, 1'b0, 48'h4444, 32'd1);         // one extent: not ranked
        send_record(1'b0, 1'b1, 1'b0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_record(1'b0, 1'b1, 1'b0, 48'h0, 32'd2);            // inode zero is a real entry
        send_record(1'b0, 1'b1, 1'b0, 48'h5, 32'd2);            // tie ranks below the older
        send_record(1'b1, 1'b1, 1'b0, 48'hABC, 32'd3);
        send_read(CMD_NONE, 1'b1, 127);                         // unused: no result
        send_read(CMD_ENTRY, 1'b0, 0);
        send_read(CMD_ENTRY, 1'b0, 1);
        send_read(CMD_ENTRY, 1'b0, 2);
        send_read(CMD_ENTRY, 1'b1, 0);
        send_read(CMD_ENTRY, 1'b0, TOP_K - 1);
        send_read(CMD_ENTRY, 1'b1, TOP_K);                      // rank out of range
        send_read(CMD_ENTRY, 1'b0, 127);
        send_read(CMD_COUNTER, 1'b0, NUM_CNT);                  // counter out of range
        send_read(CMD_COUNTER, 1'b1, 127);
        for (int c = 0; c < NUM_CNT; c++)
            send_read(CMD_COUNTER, 1'b0, c);

        // Random part: record-heavy so both tables fill and start dropping.
        n_items    = 0;
        burst_left = $urandom_range(1, 20);
        while (n_items < RAND_ITEMS) begin
            hold = (n_items % 250) == 249;
            if (hold || burst_left == 0) begin
                // Drop start for a gap; on a hold also drain all pending reads.
                start <= 1'b0;
                @(posedge i_clk);
                while (hold && mirror.outstanding() != 0)
                    @(posedge i_clk);
                gap = $urandom_range(0, 15);
                repeat (gap) @(posedge i_clk);
                if ($urandom_range(0, 4) == 0)
                    burst_left = $urandom_range(40, 150);
                else
                    burst_left = $urandom_range(1, 20);
            end
            burst_left--;

            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    ino = '0;
                else if (pick < 10)
                    ino = '1;
                else
                    ino = INO_W'({$urandom(), $urandom()});
                // Small counts give plenty of ties; wide ones exercise every bit.
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    ext = '0;
                else if (pick < 16)
                    ext = EXT_W'(1);
                else if (pick < 66)
                    ext = $urandom_range(2, 40);
                else if (pick < 86)
                    ext = $urandom_range(41, 100000);
                else
                    ext = $urandom();
                send_record($urandom_range(0, 99) < 35, $urandom_range(0, 99) < 85,
                            $urandom_range(0, 99) < 15, ino, ext);
                n_items++;
            end else if (pick < 80) begin
                if ($urandom_range(0, 99) < 80)
                    send_read(CMD_ENTRY, 1'($urandom_range(0, 1)),
                              $urandom_range(0, TOP_K - 1));
                else
                    send_read(CMD_ENTRY, 1'($urandom_range(0, 1)),
                              $urandom_range(TOP_K, 127));
                n_items++;
            end else if (pick < 95) begin
                if ($urandom_range(0, 99) < 80)
                    send_read(CMD_COUNTER, 1'($urandom_range(0, 1)),
                              $urandom_range(0, NUM_CNT - 1));
                else
                    send_read(CMD_COUNTER, 1'($urandom_range(0, 1)),
                              $urandom_range(NUM_CNT, 127));
                n_items++;
            end else begin
                // Unused command: ignored by the block, not counted.
                send_read(CMD_NONE, 1'($urandom_range(0, 1)), $urandom_range(0, 127));
            end
        end

        // Stop sending, wait out every pending read, then watch for strays.
        start <= 1'b0;
        @(posedge i_clk);
        while (mirror.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (mirror.mismatches == 0 && mirror.outstanding() == 0)
            $display("tb_top_k_fragmentation_tracker_core: done, clean");
        else
            $display("tb_top_k_fragmentation_tracker_core: done, errors");
        $finish;
    end

endmodule
